[src/fgjt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the functional graph jump table.
package fgjt_pkg;

  localparam int NODES_DEF   = 256;
  localparam int LEVELS_DEF  = 32;
  localparam int NODE_PORT_W = 8;
  localparam int STEPS_W     = 32;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RB_RD0,
    ST_RB_RD1,
    ST_RB_WR,
    ST_WALK,
    ST_DONE
  } fgjt_state_t;

  typedef struct packed {
    logic                   valid;
    logic [NODE_PORT_W-1:0] node;
  } fgjt_res_t;

endpackage

[src/fgjt_mem.sv]
`timescale 1ns / 1ps
// Jump table storage: one write port, one registered read port.
module fgjt_mem #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/fgjt_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for clearing, rebuilding and walking the jump table.
module fgjt_ctrl #(
  parameter int NODES  = fgjt_pkg::NODES_DEF,
  parameter int LEVELS = fgjt_pkg::LEVELS_DEF,
  parameter int NODE_W = (NODES > 1) ? $clog2(NODES) : 1,
  parameter int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [fgjt_pkg::NODE_PORT_W-1:0]     node,
  input  logic [fgjt_pkg::NODE_PORT_W-1:0]     succ_node,
  input  logic [fgjt_pkg::STEPS_W-1:0]         steps,
  output fgjt_pkg::fgjt_res_t                  res,
  input  logic                                 res_ready,
  output logic                                 mem_we,
  output logic [LVL_W+NODE_W-1:0]              mem_waddr,
  output logic [NODE_W-1:0]                    mem_wdata,
  output logic [LVL_W+NODE_W-1:0]              mem_raddr,
  input  logic [NODE_W-1:0]                    mem_rdata
);
  import fgjt_pkg::*;

  localparam logic [NODE_W-1:0] IDX_LAST       = NODE_W'(NODES - 1);
  localparam logic [LVL_W-1:0]  LVL_TOP        = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0]  LVL_BUILD_LAST = LVL_W'(LEVELS - 2);
  localparam logic              HAS_UPPER      = (LEVELS > 1);

  fgjt_state_t state, state_next;

  logic                   built;
  logic [LVL_W-1:0]       lvl;
  logic [NODE_W-1:0]      idx;
  logic [NODE_W-1:0]      cur;
  logic                   pend;
  logic                   oob;
  logic [NODE_PORT_W-1:0] qnode;
  logic [LEVELS-1:0]      steps_q;

  logic [LEVELS-1:0]      steps_sat;
  logic [NODE_W-1:0]      cur_now;
  logic                   wr_ok;
  logic                   need_rebuild;

  // Saturate counts that reach past the top level.
  generate
    if (LEVELS >= STEPS_W) begin : g_wide
      assign steps_sat = LEVELS'(steps);
    end else begin : g_sat
      assign steps_sat = (|(steps >> LEVELS)) ? '1 : steps[LEVELS-1:0];
    end
  endgenerate

  assign wr_ok        = (32'(node) < NODES) && (32'(succ_node) < NODES);
  assign need_rebuild = !built && HAS_UPPER;
  assign cur_now      = pend ? mem_rdata : cur;
  assign in_ready     = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (idx == IDX_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && action == ACT_QUERY) begin
          state_next = need_rebuild ? ST_RB_RD0 : ST_WALK;
        end
      end
      ST_RB_RD0: state_next = ST_RB_RD1;
      ST_RB_RD1: state_next = ST_RB_WR;
      ST_RB_WR: begin
        if (idx == IDX_LAST && lvl == LVL_BUILD_LAST) state_next = ST_WALK;
        else state_next = ST_RB_RD0;
      end
      ST_WALK: begin
        if (lvl == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {lvl, idx};
    mem_wdata = idx;
    mem_raddr = {lvl, cur_now};
    res.valid = 1'b0;
    res.node  = oob ? qnode : NODE_PORT_W'(cur_now);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {LVL_W'(0), idx};
        mem_wdata = idx;
      end
      ST_IDLE: begin
        mem_we    = in_valid && action == ACT_WRITE && wr_ok;
        mem_waddr = {LVL_W'(0), NODE_W'(node)};
        mem_wdata = NODE_W'(succ_node);
      end
      ST_RB_RD0: mem_raddr = {lvl, idx};
      ST_RB_RD1: mem_raddr = {lvl, mem_rdata};
      ST_RB_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {LVL_W'(lvl + 1'b1), idx};
        mem_wdata = mem_rdata;
      end
      ST_WALK: mem_raddr = {lvl, cur_now};
      ST_DONE: res.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      built <= 1'b0;
      idx   <= '0;
      lvl   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: idx <= idx + 1'b1;
        ST_IDLE: begin
          if (in_valid && action == ACT_WRITE && wr_ok) begin
            built <= 1'b0;
          end
          if (in_valid && action == ACT_QUERY) begin
            qnode   <= node;
            oob     <= (32'(node) >= NODES);
            steps_q <= steps_sat;
            cur     <= NODE_W'(node);
            pend    <= 1'b0;
            idx     <= '0;
            lvl     <= need_rebuild ? LVL_W'(0) : LVL_TOP;
            if (!need_rebuild) built <= 1'b1;
          end
        end
        ST_RB_WR: begin
          if (idx == IDX_LAST) begin
            idx <= '0;
            if (lvl == LVL_BUILD_LAST) begin
              lvl   <= LVL_TOP;
              built <= 1'b1;
            end else begin
              lvl <= lvl + 1'b1;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_WALK: begin
          pend <= steps_q[lvl];
          cur  <= cur_now;
          if (lvl != '0) lvl <= lvl - 1'b1;
        end
        ST_DONE: begin
          pend <= 1'b0;
          cur  <= cur_now;
        end
        default: ;
      endcase
    end
  end

  // Walk only over a table that matches the latest writes.
  a_walk_built: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> built)
    else $error("walk started on a stale table");

  // A valid write marks the table for rebuild.
  a_write_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_WRITE && wr_ok) |=> !built)
    else $error("write did not mark table for rebuild");

  // Rebuild never overwrites level 0.
  a_rebuild_upper: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RB_WR) |-> (mem_waddr[LVL_W+NODE_W-1:NODE_W] != '0))
    else $error("rebuild wrote level 0");

  // A held result has folded its last read into cur.
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && $past(state) == ST_DONE) |-> !pend)
    else $error("held result still depends on memory read data");

endmodule

[src/functional_graph_jump_table.sv]
`timescale 1ns / 1ps
// Top level: k-th successor queries over a binary-lifting jump table.
// Write transaction: taken while idle, no result; in_ready stays high.
// Query transaction: one table read per level, top level first, then the result goes to the output register.
// A query after writes first rebuilds the upper table levels, with two dependent reads
// and a write per entry on the single read port of the table memory.
// Reset: synchronous; a clearing pass over all NODES entries restores level 0 with in_ready low.
module functional_graph_jump_table #(
  parameter int NODES  = fgjt_pkg::NODES_DEF,
  parameter int LEVELS = fgjt_pkg::LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [fgjt_pkg::NODE_PORT_W-1:0] node,
  input  logic [fgjt_pkg::NODE_PORT_W-1:0] succ_node,
  input  logic [fgjt_pkg::STEPS_W-1:0]     steps,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fgjt_pkg::NODE_PORT_W-1:0] end_node
);
  import fgjt_pkg::*;

  // Node and level fields of the table address.
  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W = LVL_W + NODE_W;

  fgjt_res_t         res;
  logic              res_ready;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [NODE_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [NODE_W-1:0] mem_rdata;

  // The output register frees the sequencer: take a new result whenever the
  // register is empty or its transaction completes this cycle.
  assign res_ready = !out_valid || out_ready;

  fgjt_ctrl #(
    .NODES  (NODES),
    .LEVELS (LEVELS),
    .NODE_W (NODE_W),
    .LVL_W  (LVL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .node      (node),
    .succ_node (succ_node),
    .steps     (steps),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Table memory: level in the upper address bits, node in the lower.
  fgjt_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (NODE_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload while a transaction waits.
  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      end_node <= res.node;
    end
  end

endmodule
